// ===== rtl/core/ncd_pkg.sv =====
// Shared constants and types for the neighbor contrast corner detector.
package ncd_pkg;

    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 4096;

    localparam int PIX_W = 8;
    localparam int THR_W = 8;
    localparam int FW_W  = 12;
    localparam int FH_W  = 13;
    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);

    localparam int MIN_SIZE         = 3;
    localparam int MIN_CORNER_COUNT = 3;

    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THRESHOLD = 2'd0,
        CFG_WIDTH     = 2'd1,
        CFG_HEIGHT    = 2'd2
    } cfg_index_t;

    // One classified pixel travelling from front to back.
    typedef struct packed {
        logic [PIX_W-1:0] pix;
        logic [PIX_W-1:0] top;
        logic [PIX_W-1:0] mid;
        logic             interior;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
    } ncd_beat_t;

endpackage

// ===== rtl/core/ncd_if.sv =====
// Stream and configuration interfaces of the corner detector.
interface ncd_pixel_if import ncd_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel_value;

    modport source (output valid, output pixel_value, input ready);
    modport sink (input valid, input pixel_value, output ready);
endinterface

interface ncd_corner_if import ncd_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [COL_W-1:0] corner_column;
    logic [ROW_W-1:0] corner_row;

    modport source (output valid, output corner_column, output corner_row, input ready);
    modport sink (input valid, input corner_column, input corner_row, output ready);
endinterface

interface ncd_cfg_if import ncd_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [FH_W-1:0]      data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/ncd_front.sv =====
// Front end: pixel accept, raster position, line buffer and classification.
module ncd_front import ncd_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    ncd_pixel_if.sink          pixel,
    input  logic [FW_W-1:0]    frame_width,
    input  logic [FH_W-1:0]    frame_height,
    input  logic [Q_CW-1:0]    q_count,
    output logic               push,
    output ncd_beat_t          push_beat
);

    // Each entry holds {upper row, middle row} for one column.
    logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];
    logic [2*PIX_W-1:0] rd_data_reg;

    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;

    logic             b_valid_reg;
    logic [PIX_W-1:0] b_pix_reg;
    logic [COL_W-1:0] b_addr_reg;
    logic             b_interior_reg;
    logic [COL_W-1:0] b_col_reg;
    logic [ROW_W-1:0] b_row_reg;

    logic [FW_W-1:0]  w_eff;
    logic [FH_W-1:0]  h_eff;
    logic [FW_W-1:0]  col_ext, col_inc;
    logic [FH_W-1:0]  row_ext, row_inc;
    logic             interior;
    logic             accept;
    logic [Q_CW:0]    in_flight;

    always_comb
    begin
        if (frame_width < FW_W'(MIN_SIZE))
            w_eff = FW_W'(MIN_SIZE);
        else if (frame_width > FW_W'(MAX_WIDTH))
            w_eff = FW_W'(MAX_WIDTH);
        else
            w_eff = frame_width;

        if (frame_height < FH_W'(MIN_SIZE))
            h_eff = FH_W'(MIN_SIZE);
        else if (frame_height > FH_W'(MAX_HEIGHT))
            h_eff = FH_W'(MAX_HEIGHT);
        else
            h_eff = frame_height;
    end

    // Credit check: the stage-B beat will land in the queue next cycle.
    assign in_flight   = {1'b0, q_count} + (Q_CW+1)'(b_valid_reg);
    assign pixel.ready = (in_flight < (Q_CW+1)'(Q_DEPTH));
    assign accept      = pixel.valid && pixel.ready;

    always_comb
    begin
        col_ext  = FW_W'(col_reg);
        row_ext  = FH_W'(row_reg);
        col_inc  = col_ext + FW_W'(1);
        row_inc  = row_ext + FH_W'(1);
        interior = (col_reg >= COL_W'(2)) && (row_reg >= ROW_W'(2))
                   && (col_ext < w_eff) && (row_ext < h_eff);

        col_next = col_inc[COL_W-1:0];
        row_next = row_reg;
        if (col_inc >= w_eff)
        begin
            col_next = '0;
            if (row_inc >= h_eff)
                row_next = '0;
            else
                row_next = row_inc[ROW_W-1:0];
        end
        else if (row_ext >= h_eff)
        begin
            row_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg     <= '0;
            row_reg     <= '0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            b_valid_reg <= accept;
            if (accept)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            b_pix_reg      <= pixel.pixel_value;
            b_addr_reg     <= col_reg;
            b_interior_reg <= interior;
            b_col_reg      <= col_reg - COL_W'(1);
            b_row_reg      <= row_reg - ROW_W'(1);
        end
    end

    // Read on accept; the rotated entry is written back in the next cycle.
    // A column repeats no sooner than three beats apart, so no hazard.
    always_ff @(posedge clk)
    begin
        if (accept)
            rd_data_reg <= line_mem[col_reg];
    end

    always_ff @(posedge clk)
    begin
        if (b_valid_reg)
            line_mem[b_addr_reg] <= {rd_data_reg[PIX_W-1:0], b_pix_reg};
    end

    assign push = b_valid_reg;

    always_comb
    begin
        push_beat.pix      = b_pix_reg;
        push_beat.top      = rd_data_reg[2*PIX_W-1:PIX_W];
        push_beat.mid      = rd_data_reg[PIX_W-1:0];
        push_beat.interior = b_interior_reg;
        push_beat.col      = b_col_reg;
        push_beat.row      = b_row_reg;
    end

endmodule

// ===== rtl/core/ncd_queue.sv =====
// Short beat queue between front and back.
module ncd_queue import ncd_pkg::*; (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  ncd_beat_t       push_beat,
    input  logic            pop,
    output logic            head_valid,
    output ncd_beat_t       head_beat,
    output logic [Q_CW-1:0] count
);

    ncd_beat_t       slots [Q_DEPTH];
    logic [Q_AW-1:0] wr_ptr_reg;
    logic [Q_AW-1:0] rd_ptr_reg;
    logic [Q_CW-1:0] count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + Q_AW'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + Q_AW'(1);
            if (push && !pop)
                count_reg <= count_reg + Q_CW'(1);
            else if (pop && !push)
                count_reg <= count_reg - Q_CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slots[wr_ptr_reg] <= push_beat;
    end

    assign head_valid = (count_reg != '0);
    assign head_beat  = slots[rd_ptr_reg];
    assign count      = count_reg;

endmodule

// ===== rtl/core/ncd_back.sv =====
// Back end: 3x3 window, contrast test and output register.
module ncd_back import ncd_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic [THR_W-1:0] contrast_threshold,
    input  logic             head_valid,
    input  ncd_beat_t        head_beat,
    output logic             pop,
    ncd_corner_if.source     corner
);

    // win[0..2]: column c-2 (top, mid, bottom); win[3..5]: column c-1.
    logic [PIX_W-1:0] win_reg [6];
    logic             out_valid_reg;
    logic [COL_W-1:0] out_col_reg;
    logic [ROW_W-1:0] out_row_reg;

    logic [PIX_W-1:0] nb [8];
    logic [PIX_W:0]   hi_lim;
    logic [PIX_W:0]   centre_ext;
    logic [3:0]       bright_cnt;
    logic [3:0]       dark_cnt;
    logic             hit;

    always_comb
    begin
        nb[0] = win_reg[0];
        nb[1] = win_reg[1];
        nb[2] = win_reg[2];
        nb[3] = win_reg[3];
        nb[4] = win_reg[5];
        nb[5] = head_beat.top;
        nb[6] = head_beat.mid;
        nb[7] = head_beat.pix;

        centre_ext = {1'b0, win_reg[4]};
        hi_lim     = centre_ext + {1'b0, contrast_threshold};
        bright_cnt = '0;
        dark_cnt   = '0;
        for (int k = 0; k < 8; k++)
        begin
            // darker: nb < centre - t, rewritten as nb + t < centre
            if ({1'b0, nb[k]} > hi_lim)
                bright_cnt = bright_cnt + 4'd1;
            else if (({1'b0, nb[k]} + {1'b0, contrast_threshold}) < centre_ext)
                dark_cnt = dark_cnt + 4'd1;
        end
        hit = head_beat.interior
              && ((bright_cnt >= 4'(MIN_CORNER_COUNT)) || (dark_cnt >= 4'(MIN_CORNER_COUNT)));
    end

    assign pop = head_valid && (!out_valid_reg || corner.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 6; i++)
                win_reg[i] <= '0;
        end
        else
        begin
            if (pop)
            begin
                out_valid_reg <= hit;
                win_reg[0]    <= win_reg[3];
                win_reg[1]    <= win_reg[4];
                win_reg[2]    <= win_reg[5];
                win_reg[3]    <= head_beat.top;
                win_reg[4]    <= head_beat.mid;
                win_reg[5]    <= head_beat.pix;
            end
            else if (corner.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && hit)
        begin
            out_col_reg <= head_beat.col;
            out_row_reg <= head_beat.row;
        end
    end

    assign corner.valid         = out_valid_reg;
    assign corner.corner_column = out_col_reg;
    assign corner.corner_row    = out_row_reg;

endmodule

// ===== rtl/core/neighbor_contrast_corner_detector.sv =====
// Top level of the streaming 3x3 neighbor contrast corner detector.
//
// Channels:
//   pixel  - sink, one 8-bit grayscale pixel per beat, raster order.
//   corner - source, one keypoint (column, row) per beat, raster order.
//   cfg    - sink, register writes: 0 threshold, 1 frame width,
//            2 frame height. Always ready; write only while idle.
// Throughput: one pixel per cycle, sustained, as long as the corner
//   channel keeps up. The front holds off when the 4-beat queue, counting
//   the beat in its line-buffer read stage, would be full.
// Path: once the pixel that completes its window is accepted, a keypoint
//   passes the read stage (loaded on the accepting edge), then a queue
//   slot, then the output register.
// Reset: position, window and queue clear; threshold 20, width 640,
//   height 480. Line buffer contents are unknown until the first two rows
//   pass; no clearing pass.
// Stall: a held keypoint keeps the back from popping; the queue fills and
//   pixel.ready drops. No beat is lost or repeated.
module neighbor_contrast_corner_detector import ncd_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    ncd_pixel_if.sink    pixel,
    ncd_corner_if.source corner,
    ncd_cfg_if.sink      cfg
);

    logic [THR_W-1:0] threshold_reg;
    logic [FW_W-1:0]  width_reg;
    logic [FH_W-1:0]  height_reg;

    logic             push;
    ncd_beat_t        push_beat;
    logic             pop;
    logic             head_valid;
    ncd_beat_t        head_beat;
    logic [Q_CW-1:0]  q_count;

    // Config writes are always accepted; unknown indexes are dropped.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= THR_W'(20);
            width_reg     <= FW_W'(640);
            height_reg    <= FH_W'(480);
        end
        else if (cfg.valid)
        begin
            case (cfg_index_t'(cfg.index))
                CFG_THRESHOLD: threshold_reg <= cfg.data[THR_W-1:0];
                CFG_WIDTH:     width_reg     <= cfg.data[FW_W-1:0];
                CFG_HEIGHT:    height_reg    <= cfg.data;
                default:       ;
            endcase
        end
    end

    // Front: position tracking, line buffer read/rotate, interior tagging.
    ncd_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .pixel        (pixel),
        .frame_width  (width_reg),
        .frame_height (height_reg),
        .q_count      (q_count),
        .push         (push),
        .push_beat    (push_beat)
    );

    // Decouples the fixed-timing front from the stallable back.
    ncd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_beat  (push_beat),
        .pop        (pop),
        .head_valid (head_valid),
        .head_beat  (head_beat),
        .count      (q_count)
    );

    // Back: window shift, eight compares, keypoint output register.
    ncd_back u_back (
        .clk                (clk),
        .rst_n              (rst_n),
        .contrast_threshold (threshold_reg),
        .head_valid         (head_valid),
        .head_beat          (head_beat),
        .pop                (pop),
        .corner             (corner)
    );

endmodule
